// ----- src/dpt_pkg.sv -----
// dpt_pkg: shared types and constants for the downlink path table.
// No dependencies; used by dpt_in_if.sv, dpt_out_if.sv, downlink_path_table.sv and tb/.
package dpt_pkg;

  localparam int MAX_PATHS_DEF = 8;
  localparam int WORD_W        = 32;
  localparam int HASH_BIT_W    = 5;
  localparam int COUNT_OUT_W   = 4;

  typedef enum logic [1:0] {
    OP_UPSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    logic [WORD_W-1:0] rule_id;
    logic [WORD_W-1:0] tunnel_id;
    logic [WORD_W-1:0] outer_ipv4;
  } entry_t;

endpackage

// ----- src/dpt_in_if.sv -----
// dpt_in_if: request channel of the downlink path table (valid/ready + word).
// Depends on dpt_pkg.
interface dpt_in_if;
  logic                       valid;
  logic                       ready;
  dpt_pkg::op_t               op;
  logic [dpt_pkg::WORD_W-1:0] rule_id;
  logic                       forward_applied;
  logic                       has_forwarding;
  logic                       has_outer_header;
  logic                       dest_other_than_access;
  logic                       is_gtpu_udp_ipv4;
  logic [dpt_pkg::WORD_W-1:0] tunnel_id;
  logic [dpt_pkg::WORD_W-1:0] outer_ipv4;
  logic [dpt_pkg::WORD_W-1:0] hash_value;

  modport source (
    output valid, op, rule_id, forward_applied, has_forwarding, has_outer_header,
           dest_other_than_access, is_gtpu_udp_ipv4, tunnel_id, outer_ipv4, hash_value,
    input  ready
  );
  modport sink (
    input  valid, op, rule_id, forward_applied, has_forwarding, has_outer_header,
           dest_other_than_access, is_gtpu_udp_ipv4, tunnel_id, outer_ipv4, hash_value,
    output ready
  );
endinterface

// ----- src/dpt_out_if.sv -----
// dpt_out_if: result channel of the downlink path table (valid/ready + word).
// Depends on dpt_pkg.
interface dpt_out_if;
  logic                            valid;
  logic                            ready;
  logic                            status;
  logic                            hit;
  logic [dpt_pkg::WORD_W-1:0]      out_rule_id;
  logic [dpt_pkg::WORD_W-1:0]      out_tunnel_id;
  logic [dpt_pkg::WORD_W-1:0]      out_outer_ipv4;
  logic [dpt_pkg::COUNT_OUT_W-1:0] entry_count;

  modport source (
    output valid, status, hit, out_rule_id, out_tunnel_id, out_outer_ipv4, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, hit, out_rule_id, out_tunnel_id, out_outer_ipv4, entry_count,
    output ready
  );
endinterface

// ----- src/downlink_path_table.sv -----
// downlink_path_table: per-session downlink tunnel path table, top level.
// Depends on dpt_pkg, dpt_in_if and dpt_out_if.
//
// Entries sit packed at the bottom of a single-port-write, registered-read RAM
// of MAX_PATHS words; a fill count marks the valid ones, so reset and clear
// need no sweep. One word is worked on at a time. Upsert and remove search the
// table linearly, with a RAM read, then a compare, per entry visited; a remove
// (or an upsert of a rule that fails the downlink tunnel test) that finds its id
// then moves each later entry down one slot, with a RAM read, then a write, per
// entry. Lookup runs a bit-serial restoring remainder of the 32-bit hash by the
// count, then reads the RAM at the remainder; on an empty table it returns no hit.
// The result sits in an output register, so the next word is taken while a result still waits.
module downlink_path_table #(
  parameter int MAX_PATHS = dpt_pkg::MAX_PATHS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dpt_in_if.sink    in_ch,
  dpt_out_if.source out_ch
);

  localparam int CNT_W = $clog2(MAX_PATHS + 1);
  localparam int IDX_W = (MAX_PATHS > 1) ? $clog2(MAX_PATHS) : 1;
  localparam int W     = dpt_pkg::WORD_W;
  localparam int BW    = dpt_pkg::HASH_BIT_W;
  localparam int OW    = dpt_pkg::COUNT_OUT_W;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_FIND_RD   = 9'b000000010,
    S_FIND_CMP  = 9'b000000100,
    S_SHIFT_RD  = 9'b000001000,
    S_SHIFT_WR  = 9'b000010000,
    S_DIV       = 9'b000100000,
    S_LOOK_RD   = 9'b001000000,
    S_LOOK_WAIT = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [BW-1:0]         bit_r, bit_nxt;
  dpt_pkg::op_t          op_r, op_nxt;
  logic                  cand_r, cand_nxt;
  dpt_pkg::entry_t       item_r, item_nxt;
  logic [W-1:0]          hash_r, hash_nxt;
  logic                  res_status_r, res_status_nxt;
  logic                  res_hit_r, res_hit_nxt;
  dpt_pkg::entry_t       res_entry_r, res_entry_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_status_r, out_status_nxt;
  logic                  out_hit_r, out_hit_nxt;
  dpt_pkg::entry_t       out_entry_r, out_entry_nxt;
  logic [OW-1:0]         out_count_r, out_count_nxt;

  dpt_pkg::entry_t       mem [MAX_PATHS];
  dpt_pkg::entry_t       rd_data_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  dpt_pkg::entry_t       wr_data;

  logic                  in_fire;
  logic [CNT_W:0]        idx_inc;
  logic [CNT_W:0]        rem_shift;
  logic [CNT_W+OW-1:0]   cnt_ext;
  logic                  upsert_new;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign idx_inc   = {1'b0, idx_r} + {{CNT_W{1'b0}}, 1'b1};
  assign rem_shift = {rem_r, hash_r[W-1]};
  assign cnt_ext   = {{OW{1'b0}}, cnt_r};
  assign upsert_new = (op_r == dpt_pkg::OP_UPSERT) && cand_r;

  assign in_ch.ready          = (state_r == S_IDLE);
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.hit           = out_hit_r;
  assign out_ch.out_rule_id   = out_entry_r.rule_id;
  assign out_ch.out_tunnel_id = out_entry_r.tunnel_id;
  assign out_ch.out_outer_ipv4 = out_entry_r.outer_ipv4;
  assign out_ch.entry_count   = out_count_r;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    idx_nxt        = idx_r;
    rem_nxt        = rem_r;
    bit_nxt        = bit_r;
    op_nxt         = op_r;
    cand_nxt       = cand_r;
    item_nxt       = item_r;
    hash_nxt       = hash_r;
    res_status_nxt = res_status_r;
    res_hit_nxt    = res_hit_r;
    res_entry_nxt  = res_entry_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_hit_nxt    = out_hit_r;
    out_entry_nxt  = out_entry_r;
    out_count_nxt  = out_count_r;
    rd_addr        = idx_r[IDX_W-1:0];
    wr_en          = 1'b0;
    wr_addr        = idx_r[IDX_W-1:0];
    wr_data        = item_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_ch.op;
          cand_nxt = in_ch.forward_applied && in_ch.has_forwarding &&
                     in_ch.has_outer_header && !in_ch.dest_other_than_access &&
                     in_ch.is_gtpu_udp_ipv4;
          item_nxt.rule_id    = in_ch.rule_id;
          item_nxt.tunnel_id  = in_ch.tunnel_id;
          item_nxt.outer_ipv4 = in_ch.outer_ipv4;
          hash_nxt       = in_ch.hash_value;
          res_status_nxt = 1'b0;
          res_hit_nxt    = 1'b0;
          res_entry_nxt  = '0;
          idx_nxt        = '0;
          rem_nxt        = '0;
          bit_nxt        = '0;
          case (in_ch.op)
            dpt_pkg::OP_CLEAR: begin
              cnt_nxt   = '0;
              state_nxt = S_DONE;
            end
            dpt_pkg::OP_LOOKUP: begin
              state_nxt = (cnt_r == '0) ? S_DONE : S_DIV;
            end
            default: begin
              state_nxt = S_FIND_RD;
            end
          endcase
        end
      end

      S_FIND_RD: begin
        if (idx_r == cnt_r) begin
          // id not present
          state_nxt = S_DONE;
          if (upsert_new) begin
            if (cnt_r == CNT_W'(MAX_PATHS)) begin
              res_status_nxt = 1'b1;
            end else begin
              wr_en   = 1'b1;
              wr_addr = cnt_r[IDX_W-1:0];
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end else begin
          state_nxt = S_FIND_CMP;
        end
      end

      S_FIND_CMP: begin
        if (rd_data_r.rule_id == item_r.rule_id) begin
          if (upsert_new) begin
            wr_en     = 1'b1;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          idx_nxt   = idx_inc[CNT_W-1:0];
          state_nxt = S_FIND_RD;
        end
      end

      S_SHIFT_RD: begin
        if (idx_inc >= {1'b0, cnt_r}) begin
          cnt_nxt   = cnt_r - 1'b1;
          state_nxt = S_DONE;
        end else begin
          rd_addr   = idx_inc[IDX_W-1:0];
          state_nxt = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        wr_en     = 1'b1;
        wr_data   = rd_data_r;
        idx_nxt   = idx_inc[CNT_W-1:0];
        state_nxt = S_SHIFT_RD;
      end

      S_DIV: begin
        if (rem_shift >= {1'b0, cnt_r}) begin
          rem_nxt = CNT_W'(rem_shift - {1'b0, cnt_r});
        end else begin
          rem_nxt = rem_shift[CNT_W-1:0];
        end
        hash_nxt = {hash_r[W-2:0], 1'b0};
        bit_nxt  = bit_r + 1'b1;
        if (bit_r == BW'(W - 1)) begin
          state_nxt = S_LOOK_RD;
        end
      end

      S_LOOK_RD: begin
        rd_addr   = rem_r[IDX_W-1:0];
        state_nxt = S_LOOK_WAIT;
      end

      S_LOOK_WAIT: begin
        res_hit_nxt   = 1'b1;
        res_entry_nxt = rd_data_r;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_hit_nxt    = res_hit_r;
          out_entry_nxt  = res_entry_r;
          out_count_nxt  = cnt_ext[OW-1:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    rem_r        <= rem_nxt;
    bit_r        <= bit_nxt;
    op_r         <= op_nxt;
    cand_r       <= cand_nxt;
    item_r       <= item_nxt;
    hash_r       <= hash_nxt;
    res_status_r <= res_status_nxt;
    res_hit_r    <= res_hit_nxt;
    res_entry_r  <= res_entry_nxt;
    out_status_r <= out_status_nxt;
    out_hit_r    <= out_hit_nxt;
    out_entry_r  <= out_entry_nxt;
    out_count_r  <= out_count_nxt;
  end

  // path RAM
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_PATHS))
    else $error("entry count above table size");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("word accepted without leaving idle");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_LOOK_RD) |-> rem_r < cnt_r)
    else $error("hash remainder not below count");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT_RD || state_r == S_SHIFT_WR) |-> cnt_r != '0)
    else $error("entry move on empty table");

endmodule

// ----- tb/dpt_checker.sv -----
// dpt_checker: watches both channels of the downlink path table, keeps its own copy
// of the path table, predicts every result word and compares it field by field.
// Depends on dpt_pkg, dpt_in_if and dpt_out_if.
`timescale 1ns / 100ps

module dpt_checker (
  input  logic        clk,
  input  logic        rst_n,
  dpt_in_if           in_mon,
  dpt_out_if          out_mon,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned checked,
  output int unsigned lookup_hits,
  output int unsigned full_rejects
);

  localparam int PATHS     = dpt_pkg::MAX_PATHS_DEF;
  localparam int PRINT_CAP = 40;

  typedef struct packed {
    logic                            status;
    logic                            hit;
    logic [dpt_pkg::WORD_W-1:0]      rule_id;
    logic [dpt_pkg::WORD_W-1:0]      tunnel_id;
    logic [dpt_pkg::WORD_W-1:0]      outer_ipv4;
    logic [dpt_pkg::COUNT_OUT_W-1:0] count;
  } path_result_t;

  logic [dpt_pkg::WORD_W-1:0] path_rule [PATHS];
  logic [dpt_pkg::WORD_W-1:0] path_teid [PATHS];
  logic [dpt_pkg::WORD_W-1:0] path_ip   [PATHS];
  int unsigned                path_count;
  path_result_t               awaited_results [$];

  function automatic void clear_paths();
    for (int i = 0; i < PATHS; i++) begin
      path_rule[i] = '0;
      path_teid[i] = '0;
      path_ip[i]   = '0;
    end
    path_count = 0;
  endfunction

  function automatic int find_path(input logic [dpt_pkg::WORD_W-1:0] id);
    for (int i = 0; i < int'(path_count); i++) begin
      if (path_rule[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic void drop_path(input logic [dpt_pkg::WORD_W-1:0] id);
    int slot;
    slot = find_path(id);
    if (slot < 0) return;
    for (int i = slot; i + 1 < int'(path_count); i++) begin
      path_rule[i] = path_rule[i+1];
      path_teid[i] = path_teid[i+1];
      path_ip[i]   = path_ip[i+1];
    end
    path_count--;
    path_rule[path_count] = '0;
    path_teid[path_count] = '0;
    path_ip[path_count]   = '0;
  endfunction

  // apply one accepted request word to the shadow table, return the result it owes
  function automatic path_result_t apply_path_op();
    path_result_t r;
    int           slot;
    int unsigned  k;
    logic         candidate;
    r = '0;
    candidate = in_mon.forward_applied && in_mon.has_forwarding && in_mon.has_outer_header &&
                !in_mon.dest_other_than_access && in_mon.is_gtpu_udp_ipv4;
    case (in_mon.op)
      dpt_pkg::OP_UPSERT: begin
        if (!candidate) begin
          drop_path(in_mon.rule_id);
        end else begin
          slot = find_path(in_mon.rule_id);
          if (slot < 0) begin
            if (path_count >= PATHS) begin
              r.status = 1'b1;
              full_rejects++;
            end else begin
              slot = int'(path_count);
              path_count++;
            end
          end
          if (slot >= 0) begin
            path_rule[slot] = in_mon.rule_id;
            path_teid[slot] = in_mon.tunnel_id;
            path_ip[slot]   = in_mon.outer_ipv4;
          end
        end
      end
      dpt_pkg::OP_REMOVE: drop_path(in_mon.rule_id);
      dpt_pkg::OP_LOOKUP: begin
        if (path_count != 0) begin
          k            = in_mon.hash_value % path_count;
          r.hit        = 1'b1;
          r.rule_id    = path_rule[k];
          r.tunnel_id  = path_teid[k];
          r.outer_ipv4 = path_ip[k];
          lookup_hits++;
        end
      end
      default: clear_paths();
    endcase
    r.count = path_count[dpt_pkg::COUNT_OUT_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [dpt_pkg::WORD_W-1:0] got,
                                 input logic [dpt_pkg::WORD_W-1:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("dpt_checker: %s at %0t: got %h, expected %h", what, $time, got, want);
  endtask

  always @(posedge clk) begin
    path_result_t want;
    if (!rst_n) begin
      clear_paths();
      awaited_results.delete();
      mismatches   = 0;
      checked      = 0;
      lookup_hits  = 0;
      full_rejects = 0;
    end else begin
      if (in_mon.valid && in_mon.ready) awaited_results.push_back(apply_path_op());
      if (out_mon.valid && out_mon.ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("result word with none outstanding", 1, 0);
        end else begin
          want = awaited_results.pop_front();
          checked++;
          if (out_mon.status !== want.status)
            report_mismatch("status", 32'(out_mon.status), 32'(want.status));
          if (out_mon.hit !== want.hit)
            report_mismatch("hit", 32'(out_mon.hit), 32'(want.hit));
          if (out_mon.out_rule_id !== want.rule_id)
            report_mismatch("out_rule_id", out_mon.out_rule_id, want.rule_id);
          if (out_mon.out_tunnel_id !== want.tunnel_id)
            report_mismatch("out_tunnel_id", out_mon.out_tunnel_id, want.tunnel_id);
          if (out_mon.out_outer_ipv4 !== want.outer_ipv4)
            report_mismatch("out_outer_ipv4", out_mon.out_outer_ipv4, want.outer_ipv4);
          if (out_mon.entry_count !== want.count)
            report_mismatch("entry_count", 32'(out_mon.entry_count), 32'(want.count));
        end
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ----- tb/tb_downlink_path_table.sv -----
// tb_downlink_path_table: drives request words into the downlink path table with
// random gaps and result back-pressure; dpt_checker predicts and compares.
// Depends on dpt_pkg, dpt_in_if, dpt_out_if, downlink_path_table and dpt_checker.
`timescale 1ns / 100ps

module tb_downlink_path_table;

  localparam int          RANDOM_WORDS = 1825;
  localparam int          PHASE_WORDS  = 150;
  localparam int          CYCLE_LIMIT  = 1_000_000;
  localparam int          DRAIN_CYCLES = 80;
  localparam int          POOL_SIZE    = 12;
  // flag order: forward_applied, has_forwarding, has_outer_header,
  // dest_other_than_access, is_gtpu_udp_ipv4
  localparam logic [4:0]  FWD_RULE     = 5'b11101;
  localparam logic [4:0]  NO_FWD       = 5'b01101;
  localparam logic [4:0]  NO_PARAMS    = 5'b10101;
  localparam logic [4:0]  NO_OHC       = 5'b11001;
  localparam logic [4:0]  NOT_ACCESS   = 5'b11111;
  localparam logic [4:0]  NOT_GTPU     = 5'b11100;

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned mismatches, pending, checked, lookup_hits, full_rejects;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  logic [31:0] id_pool [POOL_SIZE];
  bit          no_gaps = 1'b0;

  dpt_in_if  in_ch ();
  dpt_out_if out_ch ();

  downlink_path_table u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dpt_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .mismatches   (mismatches),
    .pending      (pending),
    .checked      (checked),
    .lookup_hits  (lookup_hits),
    .full_rejects (full_rejects)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_downlink_path_table: FAIL");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance, or after a random gap with valid low
  task automatic send_word(input dpt_pkg::op_t op, input logic [31:0] id,
                           input logic [4:0] flags,
                           input logic [31:0] teid, input logic [31:0] ip,
                           input logic [31:0] hash);
    int gap;
    in_ch.valid      <= 1'b1;
    in_ch.op         <= op;
    in_ch.rule_id    <= id;
    {in_ch.forward_applied, in_ch.has_forwarding, in_ch.has_outer_header,
     in_ch.dest_other_than_access, in_ch.is_gtpu_udp_ipv4} <= flags;
    in_ch.tunnel_id  <= teid;
    in_ch.outer_ipv4 <= ip;
    in_ch.hash_value <= hash;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    @(negedge clk);
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic run_directed();
    send_word(dpt_pkg::OP_LOOKUP, '1, FWD_RULE, '0, '0, '1);
    send_word(dpt_pkg::OP_REMOVE, 32'h1234_5678, FWD_RULE, '0, '0, '0);
    send_word(dpt_pkg::OP_CLEAR, '0, '0, '0, '0, '0);
    send_word(dpt_pkg::OP_UPSERT, '0, FWD_RULE, '1, '0, '0);
    send_word(dpt_pkg::OP_UPSERT, '1, FWD_RULE, '0, '1, '1);
    send_word(dpt_pkg::OP_LOOKUP, '0, '0, '0, '0, '0);
    send_word(dpt_pkg::OP_LOOKUP, '0, '1, '1, '1, '1);
    for (int i = 1; i <= 6; i++)
      send_word(dpt_pkg::OP_UPSERT, i, FWD_RULE, $urandom, $urandom, $urandom);
    // table full: new id rejected, existing id still overwritten
    send_word(dpt_pkg::OP_UPSERT, 7, FWD_RULE, $urandom, $urandom, '0);
    send_word(dpt_pkg::OP_UPSERT, 3, FWD_RULE, '1, '1, '0);
    send_word(dpt_pkg::OP_LOOKUP, '0, '0, '0, '0, 7);
    // rules that fail the downlink tunnel test drop their id
    send_word(dpt_pkg::OP_UPSERT, '0, NO_FWD, $urandom, $urandom, '0);
    send_word(dpt_pkg::OP_UPSERT, 1, NO_PARAMS, $urandom, $urandom, '0);
    send_word(dpt_pkg::OP_UPSERT, 2, NO_OHC, $urandom, $urandom, '0);
    send_word(dpt_pkg::OP_UPSERT, 3, NOT_ACCESS, $urandom, $urandom, '0);
    send_word(dpt_pkg::OP_UPSERT, '1, NOT_GTPU, $urandom, $urandom, '0);
    send_word(dpt_pkg::OP_REMOVE, 99, '0, '0, '0, '0);
    send_word(dpt_pkg::OP_REMOVE, 5, '0, '0, '0, '0);
    send_word(dpt_pkg::OP_LOOKUP, '0, '0, '0, '0, 1);
    send_word(dpt_pkg::OP_CLEAR, '1, '1, '1, '1, '1);
    send_word(dpt_pkg::OP_LOOKUP, '0, '0, '0, '0, 32'h8000_0001);
  endtask

  task automatic run_random();
    int           up_weight;
    int           roll;
    dpt_pkg::op_t op;
    logic [31:0]  id, hash;
    logic [4:0]   flags;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % PHASE_WORDS == 0) begin
        case ($urandom_range(2))
          0:       up_weight = 25;
          1:       up_weight = 45;
          default: up_weight = 65;
        endcase
        no_gaps = ($urandom_range(3) == 0);
      end
      roll = $urandom_range(99);
      if (roll < up_weight)           op = dpt_pkg::OP_UPSERT;
      else if (roll < up_weight + 15) op = dpt_pkg::OP_REMOVE;
      else if (roll < 98)             op = dpt_pkg::OP_LOOKUP;
      else                            op = dpt_pkg::OP_CLEAR;
      id    = ($urandom_range(9) == 0) ? $urandom : id_pool[$urandom_range(POOL_SIZE - 1)];
      flags = ($urandom_range(4) == 0) ? 5'($urandom) : FWD_RULE;
      hash  = ($urandom_range(3) == 0) ? $urandom_range(15) : $urandom;
      send_word(op, id, flags, $urandom, $urandom, hash);
    end
  endtask

  initial begin
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      out_ch.ready <= 1'b1;
      repeat (($urandom_range(9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 12))
        @(negedge clk);
      out_ch.ready <= 1'b0;
      repeat (($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3))
        @(negedge clk);
    end
  end

  initial begin
    rst_n                        = 1'b0;
    in_ch.valid                  = 1'b0;
    in_ch.op                     = dpt_pkg::OP_UPSERT;
    in_ch.rule_id                = '0;
    in_ch.forward_applied        = 1'b0;
    in_ch.has_forwarding         = 1'b0;
    in_ch.has_outer_header       = 1'b0;
    in_ch.dest_other_than_access = 1'b0;
    in_ch.is_gtpu_udp_ipv4       = 1'b0;
    in_ch.tunnel_id              = '0;
    in_ch.outer_ipv4             = '0;
    in_ch.hash_value             = '0;
    id_pool[0] = '0;
    id_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    run_random();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("summary: %0d request words, %0d results checked, %0d mismatches",
             words_sent, checked, mismatches);
    $display("summary: %0d lookup hits, %0d upserts refused on a full table",
             lookup_hits, full_rejects);
    if (mismatches == 0) begin
      $display("tb_downlink_path_table: PASS");
    end else begin
      $display("tb_downlink_path_table: FAIL");
    end
    $finish;
  end

endmodule
